// ===== rtl/suis_pkg.sv =====
// ----------------------------------------------------------------------------
// suis_pkg
// shared types, codes and constants of the sorted unique id set
// ----------------------------------------------------------------------------
package suis_pkg;

  localparam int ID_W         = 31;
  localparam int CAPACITY_DEF = 16;

  localparam logic [ID_W-1:0] ID_LOW_RST  = 31'd1;
  localparam logic [ID_W-1:0] ID_HIGH_RST = 31'd1000000000;

  // configuration register indexes
  localparam logic CFG_ID_LOW  = 1'b0;
  localparam logic CFG_ID_HIGH = 1'b1;

  // request commands
  localparam logic [1:0] CMD_INSERT     = 2'd0;
  localparam logic [1:0] CMD_REMOVE_VAL = 2'd1;
  localparam logic [1:0] CMD_REMOVE_MIN = 2'd2;
  localparam logic [1:0] CMD_LOOKUP     = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_INSERTED = 3'd0;
  localparam logic [2:0] STAT_RANGE    = 3'd1;
  localparam logic [2:0] STAT_DUP      = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_REMOVED  = 3'd4;
  localparam logic [2:0] STAT_ABSENT   = 3'd5;
  localparam logic [2:0] STAT_FOUND    = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE_AT,
    OP_REMOVE_FIRST
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       cmp_en;
    logic       commit;
    op_t        op;
    logic [2:0] status;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       found;
    logic       in_range;
    logic       full;
    logic       empty;
  } dp_sts_t;

endpackage

// ===== rtl/suis_ctrl.sv =====
// ----------------------------------------------------------------------------
// suis_ctrl
// sequencer: compare step, update step, output register handshake
// ----------------------------------------------------------------------------
module suis_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  suis_pkg::dp_sts_t sts,
  output suis_pkg::ctrl_t   ctrl
);

  suis_pkg::state_t state_r;
  suis_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;
  logic             accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == suis_pkg::ST_IDLE) ||
                       ((state_r == suis_pkg::ST_UPD) && out_free));
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      suis_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = suis_pkg::ST_CMP;
      end
      suis_pkg::ST_CMP: begin
        state_nxt = suis_pkg::ST_UPD;
      end
      suis_pkg::ST_UPD: begin
        if (out_free) state_nxt = in_valid ? suis_pkg::ST_CMP : suis_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = suis_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl.load_in = accept;
    ctrl.cmp_en  = (state_r == suis_pkg::ST_CMP);
    ctrl.commit  = (state_r == suis_pkg::ST_UPD) && out_free;
    ctrl.op      = suis_pkg::OP_NONE;
    ctrl.status  = suis_pkg::STAT_ABSENT;
    case (sts.cmd)
      suis_pkg::CMD_INSERT: begin
        if (!sts.in_range) begin
          ctrl.status = suis_pkg::STAT_RANGE;
        end else if (sts.found) begin
          ctrl.status = suis_pkg::STAT_DUP;
        end else if (sts.full) begin
          ctrl.status = suis_pkg::STAT_FULL;
        end else begin
          ctrl.status = suis_pkg::STAT_INSERTED;
          ctrl.op     = suis_pkg::OP_INSERT;
        end
      end
      suis_pkg::CMD_REMOVE_VAL: begin
        if (sts.found) begin
          ctrl.status = suis_pkg::STAT_REMOVED;
          ctrl.op     = suis_pkg::OP_REMOVE_AT;
        end
      end
      suis_pkg::CMD_REMOVE_MIN: begin
        if (!sts.empty) begin
          ctrl.status = suis_pkg::STAT_REMOVED;
          ctrl.op     = suis_pkg::OP_REMOVE_FIRST;
        end
      end
      default: begin
        if (sts.found) ctrl.status = suis_pkg::STAT_FOUND;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= suis_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/suis_dp.sv =====
// ----------------------------------------------------------------------------
// suis_dp
// row of id cells with per-cell compare, shift network and result register
// ----------------------------------------------------------------------------
module suis_dp #(
  parameter int CAPACITY = suis_pkg::CAPACITY_DEF,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [suis_pkg::ID_W-1:0] cfg_wdata,
  input  logic [1:0]                in_cmd,
  input  logic [suis_pkg::ID_W-1:0] in_id_value,
  input  suis_pkg::ctrl_t           ctrl,
  output suis_pkg::dp_sts_t         sts,
  output logic [2:0]                out_status,
  output logic [CNT_W-1:0]          out_entry_count,
  output logic [suis_pkg::ID_W-1:0] out_smallest
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [suis_pkg::ID_W-1:0] id_low_r;
  logic [suis_pkg::ID_W-1:0] id_high_r;
  logic [1:0]                cmd_r;
  logic [suis_pkg::ID_W-1:0] val_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [suis_pkg::ID_W-1:0] ent_r   [CAPACITY];
  logic [suis_pkg::ID_W-1:0] ent_nxt [CAPACITY];
  logic [CAPACITY-1:0]       eq_r;
  logic [CAPACITY-1:0]       lt_r;
  logic [CAPACITY-1:0]       eq_nxt;
  logic [CAPACITY-1:0]       lt_nxt;
  logic                      in_range_r;
  logic [2:0]                status_r;
  logic [CNT_W-1:0]          ecount_r;
  logic [suis_pkg::ID_W-1:0] smallest_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_low_r  <= suis_pkg::ID_LOW_RST;
      id_high_r <= suis_pkg::ID_HIGH_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == suis_pkg::CFG_ID_LOW) id_low_r <= cfg_wdata;
      else id_high_r <= cfg_wdata;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r <= in_cmd;
      val_r <= in_id_value;
    end
  end

  // per-cell compare against the request id, empty cells never match
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      eq_nxt[i] = (CNT_W'(i) < count_r) && (ent_r[i] == val_r);
      lt_nxt[i] = (CNT_W'(i) < count_r) && (ent_r[i] < val_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      eq_r       <= eq_nxt;
      lt_r       <= lt_nxt;
      in_range_r <= (val_r >= id_low_r) && (val_r <= id_high_r);
    end
  end

  assign sts.cmd      = cmd_r;
  assign sts.found    = |eq_r;
  assign sts.in_range = in_range_r;
  assign sts.full     = (count_r == CAP_CNT);
  assign sts.empty    = (count_r == '0);

  // shift network: each cell picks itself, its lower or upper neighbour or the request id
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                      first_ge;
    logic [suis_pkg::ID_W-1:0] from_lo;
    logic [suis_pkg::ID_W-1:0] from_hi;

    if (g == 0) begin : g_lo0
      assign first_ge = !lt_r[g];
      assign from_lo  = ent_r[g];
    end else begin : g_lon
      assign first_ge = lt_r[g-1] && !lt_r[g];
      assign from_lo  = ent_r[g-1];
    end

    if (g == CAPACITY - 1) begin : g_hiend
      assign from_hi = ent_r[g];
    end else begin : g_hin
      assign from_hi = ent_r[g+1];
    end

    always_comb begin
      ent_nxt[g] = ent_r[g];
      case (ctrl.op)
        suis_pkg::OP_INSERT: begin
          if (first_ge) ent_nxt[g] = val_r;
          else if (!lt_r[g]) ent_nxt[g] = from_lo;
        end
        suis_pkg::OP_REMOVE_AT: begin
          if (!lt_r[g]) ent_nxt[g] = from_hi;
        end
        suis_pkg::OP_REMOVE_FIRST: begin
          ent_nxt[g] = from_hi;
        end
        default: begin
          ent_nxt[g] = ent_r[g];
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (ctrl.commit) ent_r[g] <= ent_nxt[g];
    end
  end

  always_comb begin
    case (ctrl.op)
      suis_pkg::OP_INSERT:       count_nxt = count_r + CNT_W'(1);
      suis_pkg::OP_REMOVE_AT,
      suis_pkg::OP_REMOVE_FIRST: count_nxt = count_r - CNT_W'(1);
      default:                   count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.commit) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      status_r   <= ctrl.status;
      ecount_r   <= count_nxt;
      smallest_r <= (count_nxt == '0) ? '0 : ent_nxt[0];
    end
  end

  assign out_status      = status_r;
  assign out_entry_count = ecount_r;
  assign out_smallest    = smallest_r;

endmodule

// ===== rtl/sorted_unique_id_set_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_id_set_unit
// steps: request capture, compare step, then update step, which waits while the result is stalled
// one request at a time; the next one enters during the update step or while idle
// the result register lets the next request enter while a result is stalled
// reset: synchronous active low, table empty, id range back to 1..1000000000
// ----------------------------------------------------------------------------
module sorted_unique_id_set_unit #(
  parameter int CAPACITY = suis_pkg::CAPACITY_DEF,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration writes
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [suis_pkg::ID_W-1:0] cfg_wdata,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic [suis_pkg::ID_W-1:0] in_id_value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_status,
  output logic [CNT_W-1:0]          out_entry_count,
  output logic [suis_pkg::ID_W-1:0] out_smallest
);

  // the table is a row of cells kept in ascending order; every cell
  // compares itself with the request id in the compare step, and the
  // registered equal / less-than flags steer the shift in the update step:
  // - insert opens a gap at the first cell not below the id
  // - remove by value closes the gap from the matching cell upwards
  // - remove smallest shifts the whole row down by one
  // cells at or above the count hold stale data and are never observed

  suis_pkg::ctrl_t   ctrl;
  suis_pkg::dp_sts_t sts;

  // sequencer owns the handshakes and picks the status and table operation
  suis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctrl      (ctrl)
  );

  // cells, range registers, count and result register
  suis_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_id_value     (in_id_value),
    .ctrl            (ctrl),
    .sts             (sts),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_smallest    (out_smallest)
  );

endmodule
